// ===== hdl/afc_pkg.sv =====
// Shared constants and result type for the addressed frame checker.
package afc_pkg;

    // Frame layout and bus codes
    localparam logic [8:0] HEADER_BYTES   = 9'd4;
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
    localparam logic [7:0] CMD_READ       = 8'h01;
    localparam logic [7:0] CMD_WRITE      = 8'h81;
    localparam logic [7:0] PARAM_SEARCH   = 8'h08;
    localparam logic [7:0] SEARCH_LEN     = 8'h01;

    // Header byte positions within a frame
    localparam logic [8:0] POS_ADDR  = 9'd0;
    localparam logic [8:0] POS_CMD   = 9'd1;
    localparam logic [8:0] POS_PARAM = 9'd2;
    localparam logic [8:0] POS_LEN   = 9'd3;
    localparam logic [8:0] POS_HEAD  = 9'd4;

    // Verdict codes
    localparam logic [2:0] VERD_BAD_REPLY      = 3'd0;
    localparam logic [2:0] VERD_BAD_SILENT     = 3'd1;
    localparam logic [2:0] VERD_FOREIGN_SEARCH = 3'd2;
    localparam logic [2:0] VERD_FOREIGN_IGNORE = 3'd3;
    localparam logic [2:0] VERD_READ           = 3'd4;
    localparam logic [2:0] VERD_WRITE          = 3'd5;
    localparam logic [2:0] VERD_UNHANDLED      = 3'd6;

    // One verdict item
    typedef struct packed {
        logic [7:0] first_payload;
        logic [7:0] payload_length;
        logic [7:0] param_code;
        logic [7:0] command_code;
        logic       is_broadcast;
        logic [2:0] verdict;
    } t_result;

endpackage

// ===== hdl/afc_frame.sv =====
// Frame assembly state, running checksum and verdict logic.
module afc_frame
    import afc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic [7:0] i_node_addr,
    output logic       o_hit,
    output t_result    o_result
);

    logic [8:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_param, n_param;
    logic [7:0] r_len, n_len;
    logic [7:0] r_head, n_head;
    logic [8:0] count_eff;
    logic [7:0] sum_eff;
    logic       own_addr;
    logic       bcast;

    // Restart drops the partial frame
    assign count_eff = i_start ? 9'd0 : r_count;
    assign sum_eff   = i_start ? 8'd0 : r_sum;

    // Checksum byte closes the frame
    assign o_hit    = (count_eff == ({1'b0, r_len} + HEADER_BYTES));
    assign own_addr = (r_addr == i_node_addr);
    assign bcast    = (r_addr == BROADCAST_ADDR);

    // Judge the finished frame
    always_comb begin
        o_result.is_broadcast   = bcast;
        o_result.command_code   = r_cmd;
        o_result.param_code     = r_param;
        o_result.payload_length = r_len;
        o_result.first_payload  = r_head;
        if (r_sum != i_byte) begin
            o_result.verdict = own_addr ? VERD_BAD_REPLY : VERD_BAD_SILENT;
        end else if (!own_addr && !bcast) begin
            if (r_cmd == CMD_READ && r_param == PARAM_SEARCH && r_len == SEARCH_LEN) begin
                o_result.verdict = VERD_FOREIGN_SEARCH;
            end else begin
                o_result.verdict = VERD_FOREIGN_IGNORE;
            end
        end else if (r_cmd == CMD_READ) begin
            o_result.verdict = VERD_READ;
        end else if (r_cmd == CMD_WRITE) begin
            o_result.verdict = VERD_WRITE;
        end else begin
            o_result.verdict = VERD_UNHANDLED;
        end
    end

    // Capture header bytes and the first payload byte, and advance the count and checksum
    always_comb begin
        n_addr  = r_addr;
        n_cmd   = r_cmd;
        n_param = r_param;
        n_len   = r_len;
        n_head  = r_head;
        if (o_hit) begin
            n_count = 9'd0;
            n_sum   = 8'd0;
        end else begin
            n_count = count_eff + 9'd1;
            n_sum   = sum_eff + i_byte;
            case (count_eff)
                POS_ADDR: begin
                    n_addr = i_byte;
                    n_sum  = i_byte;
                end
                POS_CMD:   n_cmd = i_byte;
                POS_PARAM: n_param = i_byte;
                POS_LEN: begin
                    n_len  = i_byte;
                    n_head = 8'd0;
                end
                POS_HEAD:  n_head = i_byte;
                default:   n_head = r_head;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 9'd0;
            r_sum   <= 8'd0;
        end else if (i_step) begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Header fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= 8'd0;
            r_cmd   <= 8'd0;
            r_param <= 8'd0;
            r_len   <= 8'd0;
            r_head  <= 8'd0;
        end else if (i_step) begin
            r_addr  <= n_addr;
            r_cmd   <= n_cmd;
            r_param <= n_param;
            r_len   <= n_len;
            r_head  <= n_head;
        end
    end

endmodule

// ===== hdl/addressed_frame_checker_core.sv =====
// Top level: input register, frame checker and result register.
//
// Takes one received bus byte per cycle unless stalled and emits one verdict item
// at the checksum byte of each frame (address, command, parameter, length, payload,
// checksum; length+5 bytes). A byte can be accepted every cycle unless stalled; the
// frame state register is updated once per byte, and a verdict passes through the
// input register and the result register to the master side. The result register
// lets the next bytes enter while a verdict waits to be taken; only a checksum byte
// stalls behind an untaken verdict. The user must write the node address through
// i_cfg_we / i_cfg_wdata while no frame is in flight; the block does not enforce it.
module addressed_frame_checker_core
    import afc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,     // node_address
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    input  logic        s_axis_tuser,    // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [7:0] command_code, [15:8] param_code,
                                         // [23:16] payload_length, [31:24] first_payload
    output logic [3:0]  m_axis_tuser     // [2:0] verdict, [3] is_broadcast
);

    logic [7:0] r_node_addr;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_out_valid;
    t_result    r_out;
    logic       hit;
    t_result    result;
    logic       out_free;
    logic       advance;

    // Hold the node address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr <= 8'd0;
        end else if (i_cfg_we) begin
            r_node_addr <= i_cfg_wdata;
        end
    end

    // Advance the held item when its verdict, if any, has room
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!hit || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    afc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_node_addr (r_node_addr),
        .o_hit       (hit),
        .o_result    (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && hit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.first_payload, r_out.payload_length,
                            r_out.param_code, r_out.command_code};
    assign m_axis_tuser  = {r_out.is_broadcast, r_out.verdict};

`ifndef ASSERT_OFF
    // A byte is never taken over a held one that does not move on
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && s_axis_tready) |-> advance)
        else $error("input register overwritten");

    // A search reply verdict only for a read of the search parameter, length one
    a_search_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2:0] == VERD_FOREIGN_SEARCH) |->
        (m_axis_tdata[7:0] == CMD_READ && m_axis_tdata[15:8] == PARAM_SEARCH &&
         m_axis_tdata[23:16] == SEARCH_LEN))
        else $error("search verdict with wrong header");

    // Read and write verdicts carry a read or write command byte
    a_cmd_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:0] == VERD_READ ||
                           m_axis_tuser[2:0] == VERD_WRITE)) |->
        (m_axis_tdata[7:0] == CMD_READ || m_axis_tdata[7:0] == CMD_WRITE))
        else $error("command verdict mismatch");

    // No verdict right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("verdict out of reset");
`endif

endmodule
